// ===== design/ita2_pkg.sv =====
`default_nettype none

package ita2_pkg;

    localparam int CODE_W = 5;
    localparam int CHAR_W = 7;
    localparam int DATA_W = 8;

    localparam logic [CODE_W-1:0] CODE_BLANK = 5'h00;
    localparam logic [CODE_W-1:0] CODE_FIGS  = 5'h1B;
    localparam logic [CODE_W-1:0] CODE_LTRS  = 5'h1F;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic MODE_LTRS = 1'b0;
    localparam logic MODE_FIGS = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

    localparam logic [DATA_W-1:0] LOWER_A    = 8'h61;
    localparam logic [DATA_W-1:0] LOWER_Z    = 8'h7A;
    localparam logic [DATA_W-1:0] CASE_DELTA = 8'h20;

    typedef struct packed {
        logic              req_type;
        logic              start_of_message;
        logic [DATA_W-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] nres;
        t_out_word  res0;
        t_out_word  res1;
        logic       next_mode;
    } t_xlate_out;

    // letters-table code for a character, zero when absent
    function automatic logic [CODE_W-1:0] enc_ltrs(input logic [DATA_W-1:0] c);
        logic [CODE_W-1:0] code;
        unique case (c)
            "E":     code = 5'd1;
            "\n":    code = 5'd2;
            "A":     code = 5'd3;
            " ":     code = 5'd4;
            "S":     code = 5'd5;
            "I":     code = 5'd6;
            "U":     code = 5'd7;
            "\r":    code = 5'd8;
            "D":     code = 5'd9;
            "R":     code = 5'd10;
            "J":     code = 5'd11;
            "N":     code = 5'd12;
            "F":     code = 5'd13;
            "C":     code = 5'd14;
            "K":     code = 5'd15;
            "T":     code = 5'd16;
            "Z":     code = 5'd17;
            "L":     code = 5'd18;
            "W":     code = 5'd19;
            "H":     code = 5'd20;
            "Y":     code = 5'd21;
            "P":     code = 5'd22;
            "Q":     code = 5'd23;
            "O":     code = 5'd24;
            "B":     code = 5'd25;
            "G":     code = 5'd26;
            "M":     code = 5'd28;
            "X":     code = 5'd29;
            "V":     code = 5'd30;
            default: code = CODE_BLANK;
        endcase
        return code;
    endfunction

    // figures code for a figure character only; nonzero means figure
    function automatic logic [CODE_W-1:0] enc_figs(input logic [DATA_W-1:0] c);
        logic [CODE_W-1:0] code;
        unique case (c)
            "3":     code = 5'd1;
            "-":     code = 5'd3;
            "'":     code = 5'd5;
            "8":     code = 5'd6;
            "7":     code = 5'd7;
            "4":     code = 5'd10;
            ",":     code = 5'd12;
            "!":     code = 5'd13;
            ":":     code = 5'd14;
            "(":     code = 5'd15;
            "5":     code = 5'd16;
            "\"":    code = 5'd17;
            ")":     code = 5'd18;
            "2":     code = 5'd19;
            "#":     code = 5'd20;
            "6":     code = 5'd21;
            "0":     code = 5'd22;
            "1":     code = 5'd23;
            "9":     code = 5'd24;
            "?":     code = 5'd25;
            "&":     code = 5'd26;
            ".":     code = 5'd28;
            "/":     code = 5'd29;
            ";":     code = 5'd30;
            default: code = CODE_BLANK;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] dec_ltrs(input logic [CODE_W-1:0] code);
        logic [DATA_W-1:0] ch;
        unique case (code)
            5'd1:    ch = "E";
            5'd2:    ch = "\n";
            5'd3:    ch = "A";
            5'd4:    ch = " ";
            5'd5:    ch = "S";
            5'd6:    ch = "I";
            5'd7:    ch = "U";
            5'd8:    ch = "\r";
            5'd9:    ch = "D";
            5'd10:   ch = "R";
            5'd11:   ch = "J";
            5'd12:   ch = "N";
            5'd13:   ch = "F";
            5'd14:   ch = "C";
            5'd15:   ch = "K";
            5'd16:   ch = "T";
            5'd17:   ch = "Z";
            5'd18:   ch = "L";
            5'd19:   ch = "W";
            5'd20:   ch = "H";
            5'd21:   ch = "Y";
            5'd22:   ch = "P";
            5'd23:   ch = "Q";
            5'd24:   ch = "O";
            5'd25:   ch = "B";
            5'd26:   ch = "G";
            5'd28:   ch = "M";
            5'd29:   ch = "X";
            5'd30:   ch = "V";
            default: ch = 8'h00;
        endcase
        return ch[CHAR_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] dec_figs(input logic [CODE_W-1:0] code);
        logic [DATA_W-1:0] ch;
        unique case (code)
            5'd1:    ch = "3";
            5'd2:    ch = "\n";
            5'd3:    ch = "-";
            5'd4:    ch = " ";
            5'd5:    ch = "'";
            5'd6:    ch = "8";
            5'd7:    ch = "7";
            5'd8:    ch = "\r";
            5'd10:   ch = "4";
            5'd12:   ch = ",";
            5'd13:   ch = "!";
            5'd14:   ch = ":";
            5'd15:   ch = "(";
            5'd16:   ch = "5";
            5'd17:   ch = "\"";
            5'd18:   ch = ")";
            5'd19:   ch = "2";
            5'd20:   ch = "#";
            5'd21:   ch = "6";
            5'd22:   ch = "0";
            5'd23:   ch = "1";
            5'd24:   ch = "9";
            5'd25:   ch = "?";
            5'd26:   ch = "&";
            5'd28:   ch = ".";
            5'd29:   ch = "/";
            5'd30:   ch = ";";
            default: ch = 8'h00;
        endcase
        return ch[CHAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/ita2_xlate.sv =====
`default_nettype none

module ita2_xlate (
    input  ita2_pkg::t_in_word   i_item,
    input  logic                 i_mode,
    input  logic                 i_unshift,
    output ita2_pkg::t_xlate_out o_res
);
    import ita2_pkg::*;

    logic              mode0;
    logic [DATA_W-1:0] c_up;
    logic [CODE_W-1:0] fig_code;
    logic [CODE_W-1:0] enc_code;
    logic              is_fig;
    logic [CODE_W-1:0] dcode;
    logic [CHAR_W-1:0] dchar;

    always_comb begin
        mode0 = i_item.start_of_message ? MODE_LTRS : i_mode;

        // encode path
        c_up = i_item.data_in;
        if (i_item.data_in >= LOWER_A && i_item.data_in <= LOWER_Z) begin
            c_up = i_item.data_in - CASE_DELTA;
        end
        fig_code = enc_figs(c_up);
        is_fig   = (fig_code != CODE_BLANK);
        enc_code = is_fig ? fig_code : enc_ltrs(c_up);

        // decode path
        dcode = i_item.data_in[CODE_W-1:0];
        dchar = (mode0 == MODE_FIGS) ? dec_figs(dcode) : dec_ltrs(dcode);

        o_res.nres      = 2'd0;
        o_res.res0      = '0;
        o_res.res1      = '0;
        o_res.next_mode = mode0;

        if (i_item.req_type == REQ_ENCODE) begin
            o_res.next_mode = is_fig ? MODE_FIGS : MODE_LTRS;
            if (is_fig != mode0) begin
                // shift word first, then the character code
                o_res.nres          = 2'd2;
                o_res.res0.code_out = is_fig ? CODE_FIGS : CODE_LTRS;
                o_res.res1.code_out = enc_code;
                o_res.res1.last     = 1'b1;
            end else begin
                o_res.nres          = 2'd1;
                o_res.res0.code_out = enc_code;
                o_res.res0.last     = 1'b1;
            end
        end else begin
            priority if (dcode == CODE_FIGS) begin
                o_res.next_mode = MODE_FIGS;
            end else if (dcode == CODE_LTRS) begin
                o_res.next_mode = MODE_LTRS;
            end else if (dchar != CHAR_NONE) begin
                o_res.nres          = 2'd1;
                o_res.res0.char_out = dchar;
                o_res.res0.last     = 1'b1;
                if (i_unshift && dchar == CHAR_SPACE) begin
                    o_res.next_mode = MODE_LTRS;
                end
            end else begin
                o_res.nres = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ita2_baudot_codec.sv =====
// channel   dir   handshake              payload
// in        in    i_in_valid/o_in_stall   i_in_data  (t_in_word)
// out       out   o_out_valid/i_out_stall o_out_data (t_out_word)
// cfg       in    i_cfg_valid/o_cfg_ready i_cfg_data (unshift_on_space)
//
// an item is held in the input register, then its words go into a
// two-word output queue register whose head word drives the output;
// an encode needing a shift gives two words, a decoded shift or unknown code none,
// every other item one; one word leaves the queue per cycle unless i_out_stall
// synchronous active-low reset sets letters, clears unshift, empties both stages
// the input stalls while the queue cannot take all words of the registered item
`default_nettype none

module ita2_baudot_codec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ita2_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ita2_pkg::t_out_word o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import ita2_pkg::*;

    logic       r_in_vld;
    logic       n_in_vld;
    t_in_word   r_in;
    logic       r_mode;
    logic       r_unshift;
    t_out_word  r_q0;
    t_out_word  r_q1;
    t_out_word  n_q0;
    t_out_word  n_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    t_xlate_out xl;
    logic       pop;
    logic [1:0] base;
    logic       move;
    logic       in_take;

    ita2_xlate u_xlate (
        .i_item    (r_in),
        .i_mode    (r_mode),
        .i_unshift (r_unshift),
        .o_res     (xl)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_comb begin
        pop        = (r_cnt != 2'd0) && !i_out_stall;
        base       = r_cnt - {1'b0, pop};
        // the item moves only when every word it makes fits in the queue
        move       = r_in_vld && (xl.nres <= (2'd2 - base));
        o_in_stall = r_in_vld && !move;
        in_take    = i_in_valid && !o_in_stall;
        n_in_vld   = in_take || (r_in_vld && !move);
    end

    always_comb begin
        n_q0  = pop ? r_q1 : r_q0;
        n_q1  = r_q1;
        n_cnt = base;
        if (move) begin
            unique case (base)
                2'd0: begin
                    n_q0 = xl.res0;
                    n_q1 = xl.res1;
                end
                2'd1: begin
                    n_q1 = xl.res0;
                end
                default: begin
                end
            endcase
            n_cnt = base + xl.nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_cnt     <= 2'd0;
            r_mode    <= MODE_LTRS;
            r_unshift <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
            r_cnt    <= n_cnt;
            if (move) begin
                r_mode <= xl.next_mode;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_unshift <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_encode_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in.req_type == REQ_ENCODE) |-> (xl.nres != 2'd0))
        else $error("encode item produced no word");

    a_not_last_is_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |->
        (o_out_data.code_out == CODE_FIGS || o_out_data.code_out == CODE_LTRS))
        else $error("non-final word is not a shift code");

    a_char_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.char_out != CHAR_NONE) |->
        (o_out_data.code_out == CODE_BLANK && o_out_data.last))
        else $error("decoded word carries a code");
`endif

endmodule

`default_nettype wire
